FILE: hw/rtl/gsd_pkg.sv
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types, constants and step functions for the Gold-sequence
// descrambler: payload structs, sequencer states and the register steps.
// ----------------------------------------------------------------------------
package gsd_pkg;

    // sequence and sample geometry
    localparam int LFSR_W     = 31;
    localparam int SAMPLE_W   = 16;
    localparam int OFFSET_W   = 12;
    localparam int COUNT_W    = 13;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;

    // fixed chips skipped on every restart
    localparam logic [COUNT_W-1:0] SKIP_CHIPS = COUNT_W'(1600);

    // function codes of an input request
    localparam logic FUNC_RESTART = 1'b0;
    localparam logic FUNC_SAMPLE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOLD_SEED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_OFFSET = CFG_IDX_W'(1);

    // saturation bounds of a soft value
    localparam logic signed [SAMPLE_W-1:0] SOFT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SOFT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // input request payload
    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] soft_in;
    } item_t;

    // result payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] soft_out;
        logic                       chip_bit;
    } result_t;

    // sequencer states
    typedef enum logic {
        GSD_IDLE,
        GSD_SKIP
    } gsd_state_t;

    // sequencer to shift-register unit control
    typedef struct packed {
        logic load;
        logic step;
        logic busy;
    } lfsr_ctrl_t;

    // first register: x1(n+31) = x1(n+3) ^ x1(n)
    function automatic logic [LFSR_W-1:0] step_first(input logic [LFSR_W-1:0] x);
        step_first = {x[0] ^ x[3], x[LFSR_W-1:1]};
    endfunction

    // second register: x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
    function automatic logic [LFSR_W-1:0] step_second(input logic [LFSR_W-1:0] x);
        step_second = {x[0] ^ x[1] ^ x[2] ^ x[3], x[LFSR_W-1:1]};
    endfunction

endpackage

FILE: hw/rtl/gsd_lfsr.sv
// ----------------------------------------------------------------------------
// gsd_lfsr
// Pair of 31-bit shift registers with one shared step unit. Loads from the
// seed on restart and advances one chip per step command.
// ----------------------------------------------------------------------------
module gsd_lfsr
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gsd_pkg::lfsr_ctrl_t          ctrl,
    input  logic [gsd_pkg::LFSR_W-1:0]   seed,
    output logic                         chip
);

    logic [gsd_pkg::LFSR_W-1:0] first_reg;
    logic [gsd_pkg::LFSR_W-1:0] first_next;
    logic [gsd_pkg::LFSR_W-1:0] second_reg;
    logic [gsd_pkg::LFSR_W-1:0] second_next;

    // current chip is the xor of the two lowest bits
    assign chip = first_reg[0] ^ second_reg[0];

    // load or step
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        if (ctrl.load)
        begin
            first_next  = gsd_pkg::LFSR_W'(1);
            second_next = seed;
        end
        else if (ctrl.step)
        begin
            first_next  = gsd_pkg::step_first(first_reg);
            second_next = gsd_pkg::step_second(second_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= gsd_pkg::LFSR_W'(1);
            second_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

FILE: hw/rtl/gsd_seq.sv
// ----------------------------------------------------------------------------
// gsd_seq
// Sequencer: steps the registers once per sample; on a restart it loads them
// and then once per cycle through the fixed skip plus the configured offset.
// ----------------------------------------------------------------------------
module gsd_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          func,
    input  logic [gsd_pkg::OFFSET_W-1:0]  chip_offset,
    output gsd_pkg::lfsr_ctrl_t           ctrl
);

    gsd_pkg::gsd_state_t          state_reg;
    gsd_pkg::gsd_state_t          state_next;
    logic [gsd_pkg::COUNT_W-1:0]  count_reg;
    logic [gsd_pkg::COUNT_W-1:0]  count_next;
    logic [gsd_pkg::COUNT_W-1:0]  skip_total;

    assign skip_total = gsd_pkg::SKIP_CHIPS + gsd_pkg::COUNT_W'(chip_offset);

    // next state and skip counter
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            gsd_pkg::GSD_IDLE:
            begin
                if (start && (func == gsd_pkg::FUNC_RESTART))
                begin
                    count_next = skip_total;
                    if (skip_total != '0)
                    begin
                        state_next = gsd_pkg::GSD_SKIP;
                    end
                end
            end
            gsd_pkg::GSD_SKIP:
            begin
                count_next = count_reg - gsd_pkg::COUNT_W'(1);
                if (count_reg == gsd_pkg::COUNT_W'(1))
                begin
                    state_next = gsd_pkg::GSD_IDLE;
                end
            end
            default:
            begin
                state_next = gsd_pkg::GSD_IDLE;
                count_next = '0;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            gsd_pkg::GSD_IDLE:
            begin
                ctrl.load = start && (func == gsd_pkg::FUNC_RESTART);
                ctrl.step = start && (func == gsd_pkg::FUNC_SAMPLE);
            end
            gsd_pkg::GSD_SKIP:
            begin
                ctrl.step = 1'b1;
                ctrl.busy = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsd_pkg::GSD_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/gsd_sign.sv
// ----------------------------------------------------------------------------
// gsd_sign
// Sign flip with saturation and the result output register.
// ----------------------------------------------------------------------------
module gsd_sign
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic signed [gsd_pkg::SAMPLE_W-1:0] soft_in,
    input  logic                               chip,
    input  logic                               result_stall,
    output logic                               result_valid,
    output gsd_pkg::result_t                   result
);

    logic                   valid_reg;
    logic                   valid_next;
    gsd_pkg::result_t       data_reg;
    gsd_pkg::result_t       data_next;

    // flip sign on a one chip, most negative value saturates
    always_comb
    begin
        data_next.chip_bit = chip;
        if (!chip)
        begin
            data_next.soft_out = soft_in;
        end
        else if (soft_in == gsd_pkg::SOFT_MIN)
        begin
            data_next.soft_out = gsd_pkg::SOFT_MAX;
        end
        else
        begin
            data_next.soft_out = -soft_in;
        end
    end

    // output valid: set on load, cleared once taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

FILE: hw/rtl/gold_sequence_descrambler.sv
// ----------------------------------------------------------------------------
// gold_sequence_descrambler
// Gold sequence generator with two 31-bit registers and soft-sample descrambler.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   gsd_pkg::item_t
//   result    out        result_valid / result_stall gsd_pkg::result_t
//   config    in         cfg_we                    cfg_index, cfg_data
//
// A sample request's result sits in the output register the next cycle,
// and a new sample is taken while it drains unless result_stall holds it.
// A restart request loads the registers and skips 1600 + chip_offset chips:
// the shared step unit advances both registers one chip per cycle, and
// item_stall is high during the skip. A restart gives no result.
// After reset the sequence runs from first register 1, second register 0.
// ----------------------------------------------------------------------------
module gold_sequence_descrambler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  gsd_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gsd_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [gsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [gsd_pkg::LFSR_W-1:0]    gold_seed_reg;
    logic [gsd_pkg::OFFSET_W-1:0]  chip_offset_reg;
    gsd_pkg::lfsr_ctrl_t           ctrl;
    logic                          accept;
    logic                          chip;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gold_seed_reg   <= '0;
            chip_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gsd_pkg::CFG_GOLD_SEED:
                begin
                    gold_seed_reg <= cfg_data[gsd_pkg::LFSR_W-1:0];
                end
                gsd_pkg::CFG_CHIP_OFFSET:
                begin
                    chip_offset_reg <= cfg_data[gsd_pkg::OFFSET_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // input handshake
    assign item_stall = ctrl.busy || (result_valid && result_stall);
    assign accept     = item_valid && !item_stall;

    gsd_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .func        (item.func),
        .chip_offset (chip_offset_reg),
        .ctrl        (ctrl)
    );

    gsd_lfsr u_lfsr
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .seed  (gold_seed_reg),
        .chip  (chip)
    );

    gsd_sign u_sign
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept && (item.func == gsd_pkg::FUNC_SAMPLE)),
        .soft_in      (item.soft_in),
        .chip         (chip),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: hw/rtl/gsd_checker.sv
// ----------------------------------------------------------------------------
// gsd_checker
// Port-level checks of the descrambler: result timing, sign flip and
// stall behavior after a restart.
// ----------------------------------------------------------------------------
module gsd_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_stall,
    input  gsd_pkg::item_t                    item,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  gsd_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [gsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic sample_acc;
    logic restart_acc;
    logic cfg_seen;

    assign sample_acc  = item_valid && !item_stall && (item.func == gsd_pkg::FUNC_SAMPLE);
    assign restart_acc = item_valid && !item_stall && (item.func == gsd_pkg::FUNC_RESTART);
    assign cfg_seen    = cfg_we && (cfg_index == cfg_index) && (cfg_data == cfg_data);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // every sample request gives a result the next cycle
    a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> result_valid)
        else $error("sample request gave no result");

    // zero chip passes the value through
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (result.chip_bit || (result.soft_out == $past(item.soft_in))))
        else $error("soft value altered on zero chip");

    // one chip negates, saturating the most negative value
    a_negate: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (!result.chip_bit ||
            (($past(item.soft_in) == gsd_pkg::SOFT_MIN) && (result.soft_out == gsd_pkg::SOFT_MAX)) ||
            (($past(item.soft_in) != gsd_pkg::SOFT_MIN) &&
             (result.soft_out == -$past(item.soft_in)))))
        else $error("soft value not negated on one chip");

    // input is held off once a restart is taken, unless a config write comes with it
    a_restart_stall: assert property (@(posedge clk) disable iff (!rst_n)
        restart_acc && !cfg_seen |=> item_stall)
        else $error("request taken during restart skip");

endmodule

bind gold_sequence_descrambler gsd_checker u_gsd_checker (.*);
